/* sv/detm_pkg.sv */
// ----------------------------------------------------------------------------
// detm_pkg
// Shared types and constants of the dual-encoding token matcher.
// ----------------------------------------------------------------------------
package detm_pkg;

  localparam int TokLen   = 5;   // token length in characters
  localparam int WinDepth = 14;  // bytes of history kept
  localparam int FillW    = 4;   // bits of the window fill count
  localparam int DistW    = 4;   // bits of a hit's distance back from the newest byte
  localparam int ResDepth = 4;   // result queue entries
  localparam int ResCntW  = 3;   // bits of the result queue count
  localparam int ResPtrW  = 2;   // bits of a result queue pointer
  localparam int OffW     = 32;  // reported offset width
  localparam int CfgIdxW  = 3;   // bits of a configuration register index

  // hit encodings
  localparam logic EncAscii = 1'b0;
  localparam logic EncUtf16 = 1'b1;

  typedef logic [WinDepth-1:0][7:0] win_t;  // index 0 is the newest byte
  typedef logic [TokLen-1:0][7:0]   tok_t;

  // reset token "frida"
  localparam tok_t TokReset = {8'h61, 8'h64, 8'h69, 8'h72, 8'h66};

  // hits found for one byte, first two in reporting order
  typedef struct packed {
    logic [1:0]       num;
    logic             enc0;
    logic [DistW-1:0] dist0;
    logic             enc1;
    logic [DistW-1:0] dist1;
  } hit_sum_t;

  // one result beat
  typedef struct packed {
    logic            encoding;
    logic [OffW-1:0] match_offset;
    logic            run_last;
  } res_t;

endpackage

/* sv/detm_in_if.sv */
// ----------------------------------------------------------------------------
// detm_in_if
// Byte input channel: valid/ready handshake with data byte and blob end flag.
// ----------------------------------------------------------------------------
interface detm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       blob_end;

  modport source (output valid, output data_byte, output blob_end, input ready);
  modport sink   (input valid, input data_byte, input blob_end, output ready);
endinterface

/* sv/detm_out_if.sv */
// ----------------------------------------------------------------------------
// detm_out_if
// Hit output channel: valid/ready handshake with encoding, offset, run flag.
// ----------------------------------------------------------------------------
interface detm_out_if;
  logic        valid;
  logic        ready;
  logic        encoding;
  logic [31:0] match_offset;
  logic        run_last;

  modport source (output valid, output encoding, output match_offset, output run_last,
                  input ready);
  modport sink   (input valid, input encoding, input match_offset, input run_last,
                  output ready);
endinterface

/* sv/detm_hit.sv */
// ----------------------------------------------------------------------------
// detm_hit
// Window compare: finds ASCII and UTF-16LE token hits with word boundaries.
// ----------------------------------------------------------------------------
module detm_hit
  import detm_pkg::*;
(
  input  win_t             win_i,
  input  logic [FillW-1:0] fill_i,
  input  logic             last_i,
  input  tok_t             tok_i,
  output hit_sum_t         hit_o
);

  localparam int NumCand = 5;

  function automatic logic is_word(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || (c == 8'h5f);
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  // token starting d bytes before the newest byte
  function automatic logic ascii_hit(int d, win_t w, logic [FillW-1:0] f, tok_t t);
    logic ok;
    ok = (int'(f) >= d + 1);
    for (int i = 0; i < TokLen; i++) begin
      if (fold(w[d-i]) != t[i]) ok = 1'b0;
    end
    if (int'(f) >= d + 2 && is_word(w[d+1])) ok = 1'b0;
    if (d >= 5 && is_word(w[d-5])) ok = 1'b0;
    return ok;
  endfunction

  function automatic logic utf16_hit(int d, win_t w, logic [FillW-1:0] f, tok_t t);
    logic ok;
    ok = (int'(f) >= d + 1);
    for (int i = 0; i < TokLen; i++) begin
      if (fold(w[d-2*i]) != t[i]) ok = 1'b0;
      if (w[d-2*i-1] != 8'h00) ok = 1'b0;
    end
    if (int'(f) >= d + 3 && w[d+1] == 8'h00 && is_word(w[d+2])) ok = 1'b0;
    if (d >= 11 && w[d-11] == 8'h00 && is_word(w[d-10])) ok = 1'b0;
    return ok;
  endfunction

  logic [NumCand-1:0]            cand;
  logic [NumCand-1:0]            cand_enc;
  logic [NumCand-1:0][DistW-1:0] cand_dist;

  // reporting order: ASCII before UTF-16, lower offset first
  always_comb begin
    cand[0] = ascii_hit(5, win_i, fill_i, tok_i);
    cand[1] = last_i && ascii_hit(4, win_i, fill_i, tok_i);
    cand[2] = utf16_hit(11, win_i, fill_i, tok_i);
    cand[3] = last_i && utf16_hit(10, win_i, fill_i, tok_i);
    cand[4] = last_i && utf16_hit(9, win_i, fill_i, tok_i);
    cand_enc  = {EncUtf16, EncUtf16, EncUtf16, EncAscii, EncAscii};
    cand_dist = {DistW'(9), DistW'(10), DistW'(11), DistW'(4), DistW'(5)};
  end

  // keep the first two, drop the rest
  always_comb begin
    hit_o = '0;
    for (int k = 0; k < NumCand; k++) begin
      if (cand[k]) begin
        if (hit_o.num == 2'd0) begin
          hit_o.enc0  = cand_enc[k];
          hit_o.dist0 = cand_dist[k];
          hit_o.num   = 2'd1;
        end else if (hit_o.num == 2'd1) begin
          hit_o.enc1  = cand_enc[k];
          hit_o.dist1 = cand_dist[k];
          hit_o.num   = 2'd2;
        end
      end
    end
  end

endmodule

/* sv/detm_fifo.sv */
// ----------------------------------------------------------------------------
// detm_fifo
// Result queue: up to two pushes a cycle, one beat out a cycle while ready.
// ----------------------------------------------------------------------------
module detm_fifo
  import detm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_cnt_i,
  input  res_t [1:0]         push_data_i,
  output logic [ResCntW-1:0] count_o,
  detm_out_if.source         out_o
);

  res_t [ResDepth-1:0] mem_q;
  logic [ResPtrW-1:0]  wr_q, wr_d;
  logic [ResPtrW-1:0]  rd_q, rd_d;
  logic [ResCntW-1:0]  cnt_q, cnt_d;
  logic                pop;

  assign pop = out_o.valid && out_o.ready;

  always_comb begin
    wr_d  = wr_q + ResPtrW'(push_cnt_i);
    rd_d  = rd_q + ResPtrW'(pop);
    cnt_d = cnt_q + ResCntW'(push_cnt_i) - ResCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push_data_i[0];
    if (push_cnt_i == 2'd2) mem_q[wr_q + ResPtrW'(1)] <= push_data_i[1];
  end

  assign count_o            = cnt_q;
  assign out_o.valid        = (cnt_q != '0);
  assign out_o.encoding     = mem_q[rd_q].encoding;
  assign out_o.match_offset = mem_q[rd_q].match_offset;
  assign out_o.run_last     = mem_q[rd_q].run_last;

endmodule

/* sv/dual_encoding_token_matcher.sv */
// ----------------------------------------------------------------------------
// dual_encoding_token_matcher
// Whole-token, case-insensitive search for a 5-byte token in ASCII and
// UTF-16LE form over a byte stream split into blobs.
// ----------------------------------------------------------------------------
// Takes one byte per clock. A byte accepted shifts into a 14-byte window;
// in the next cycle the window compare result is written into a 4-entry
// result queue. Each byte yields zero, one or two hits (two only at a blob
// end or when an ASCII and a UTF-16 hit close at the same byte); the output
// moves one beat per clock while its ready is high, so the queue drain rate
// is what sets throughput: inputs are taken back to back as long as the
// queue holds at most two entries once the byte in the compare stage has
// pushed its hits. A hit is reported when its right neighbor arrives or at
// blob end, ASCII before UTF-16 within one byte, with run_last marking the
// last hit of that byte. Offsets count from the blob start; the byte
// position sticks at 2^OFFSET_BITS-1, and offsets past 32 bits read as all
// ones. Token registers may only be written while the block is idle;
// writes to indexes past the fifth are ignored.
// ----------------------------------------------------------------------------
module dual_encoding_token_matcher
  import detm_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  detm_in_if.sink            in_i,
  detm_out_if.source         out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_data_i
);

  // wide enough to spot offsets above 32 bits for any OFFSET_BITS
  localparam int WideW = (OFFSET_BITS > OffW) ? OFFSET_BITS : OffW + 1;

  // token registers
  tok_t tok_q;

  // blob state
  win_t                   win_q;
  logic [FillW-1:0]       fill_q, fill_d, fill_inc;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;

  // compare stage: what the newest byte in the window needs
  logic                   stage_vld_q;
  logic                   stage_last_q;
  logic [FillW-1:0]       stage_fill_q;
  logic [OFFSET_BITS-1:0] stage_pos_q;

  logic                   in_beat;
  hit_sum_t               hit;
  logic [1:0]             push_cnt;
  res_t [1:0]             push_data;
  logic [ResCntW-1:0]     q_count;

  assign in_beat = in_i.valid && in_i.ready;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= TokReset;
    end else if (cfg_we_i && (int'(cfg_idx_i) < TokLen)) begin
      tok_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // ---- window and blob counters ----
  always_comb begin
    fill_inc = (int'(fill_q) < WinDepth) ? fill_q + FillW'(1) : fill_q;
    fill_d   = in_i.blob_end ? '0 : fill_inc;
    if (in_i.blob_end) begin
      pos_d = '0;
    end else if (pos_q != '1) begin
      pos_d = pos_q + OFFSET_BITS'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= '0;
      fill_q       <= '0;
      pos_q        <= '0;
      stage_vld_q  <= 1'b0;
      stage_last_q <= 1'b0;
      stage_fill_q <= '0;
      stage_pos_q  <= '0;
    end else begin
      stage_vld_q <= in_beat;
      if (in_beat) begin
        win_q        <= {win_q[WinDepth-2:0], in_i.data_byte};
        fill_q       <= fill_d;
        pos_q        <= pos_d;
        stage_last_q <= in_i.blob_end;
        stage_fill_q <= fill_inc;
        stage_pos_q  <= pos_q;
      end
    end
  end

  // ---- window compare ----
  detm_hit u_hit (
    .win_i  (win_q),
    .fill_i (stage_fill_q),
    .last_i (stage_last_q),
    .tok_i  (tok_q),
    .hit_o  (hit)
  );

  function automatic logic [OffW-1:0] hit_offset(logic [OFFSET_BITS-1:0] p,
                                                 logic [DistW-1:0] d);
    logic [WideW-1:0] pw;
    logic [WideW-1:0] dw;
    logic [WideW-1:0] off;
    pw  = WideW'(p);
    dw  = WideW'(d);
    off = (pw >= dw) ? pw - dw : '0;
    return (off > WideW'({OffW{1'b1}})) ? {OffW{1'b1}} : off[OffW-1:0];
  endfunction

  always_comb begin
    push_cnt = stage_vld_q ? hit.num : 2'd0;
    push_data[0].encoding     = hit.enc0;
    push_data[0].match_offset = hit_offset(stage_pos_q, hit.dist0);
    push_data[0].run_last     = (hit.num == 2'd1);
    push_data[1].encoding     = hit.enc1;
    push_data[1].match_offset = hit_offset(stage_pos_q, hit.dist1);
    push_data[1].run_last     = 1'b1;
  end

  // a new byte may push two hits next cycle: leave room for them
  assign in_i.ready = ((q_count + ResCntW'(push_cnt)) <= ResCntW'(ResDepth - 2));

  // ---- result queue ----
  detm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_data_i (push_data),
    .count_o     (q_count),
    .out_o       (out_o)
  );

  // ---- assertions ----
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_vld_q |-> (int'(q_count) + int'(hit.num) <= ResDepth))
    else $error("result queue overflow");

  a_blob_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && in_i.blob_end) |=> (pos_q == '0 && fill_q == '0))
    else $error("blob end did not restart position and fill");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && !in_i.blob_end && pos_q != '1) |=>
      (pos_q == $past(pos_q) + OFFSET_BITS'(1)))
    else $error("byte position did not advance");

  a_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_vld_q && hit.num == 2'd2) |-> !push_data[0].run_last)
    else $error("first of two hits flagged as run end");

endmodule
